// ----- hw/rtl/bbpf_pkg.sv -----
// Shared types and constants of the beam break position filter.
package bbpf_pkg;

   localparam int X_IN_W  = 32;
   localparam int Y_IN_W  = 16;
   localparam int POS_X_W = 7;
   localparam int POS_Y_W = 6;
   localparam int CNT_W   = 8;
   localparam int STK_W   = 11;
   localparam int LIMIT_W = 10;
   localparam int STEP_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SAMPLES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STUCK_LIMIT    = 2'd2;

   localparam logic [CNT_W-1:0]   WINDOW_SAMPLES_RST = 8'd10;
   localparam logic [LIMIT_W-1:0] STUCK_LIMIT_RST    = 10'd500;

   typedef struct packed {
      logic              load;
      logic              run;
      logic              close;
      logic              clear_stuck;
      logic              track_mode;
      logic [STEP_W-1:0] step;
   } lane_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_COUNT = 4'b0010,
      ST_CLOSE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

endpackage

// ----- hw/rtl/bbpf_if.sv -----
// Handshake channel interfaces for beam samples and filtered results.
interface bbpf_req_if;
   import bbpf_pkg::*;
   logic              valid;
   logic              ready;
   logic [X_IN_W-1:0] x_beam_breaks;
   logic [Y_IN_W-1:0] y_beam_breaks;
   modport source (output valid, output x_beam_breaks, output y_beam_breaks, input ready);
   modport sink (input valid, input x_beam_breaks, input y_beam_breaks, output ready);
endinterface

interface bbpf_rsp_if;
   import bbpf_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [POS_X_W-1:0] pos_x;
   logic signed [POS_Y_W-1:0] pos_y;
   logic [X_IN_W-1:0]         x_filtered_mask;
   logic [Y_IN_W-1:0]         y_filtered_mask;
   modport source (output valid, output pos_x, output pos_y, output x_filtered_mask,
                   output y_filtered_mask, input ready);
   modport sink (input valid, input pos_x, input pos_y, input x_filtered_mask,
                 input y_filtered_mask, output ready);
endinterface

// ----- hw/rtl/beam_break_position_filter_top.sv -----
// Top level of the beam break position filter: control sequencer, registers and result stage.
//
//   channel  direction  handshake         payload
//   req_port in         valid/ready       x_beam_breaks, y_beam_breaks
//   rsp_port out        valid/ready       pos_x, pos_y, x_filtered_mask, y_filtered_mask
//   csr      in         csr_wr_en only    csr_index, csr_data
//
// A counted sample walks N beam steps; a window-closing sample adds an emit step, where
// N = max(min(X_BEAMS,32), min(Y_BEAMS,16)); the lanes walk one beam per cycle.
// A closing sample waits in the emit step while the result register is full and not being taken.
// Synchronous reset clears counters, stuck state and result valid, sets held positions to ones
// and loads register defaults. req_port.ready is high only between samples.
module beam_break_position_filter_top #(
   parameter int X_BEAMS = 32,
   parameter int Y_BEAMS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   bbpf_req_if.sink                        req_port,
   bbpf_rsp_if.source                      rsp_port,
   input  logic                            csr_wr_en,
   input  logic [bbpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bbpf_pkg::CSR_DATA_W-1:0] csr_data
);
   import bbpf_pkg::*;

   localparam int DX    = (X_BEAMS < X_IN_W) ? X_BEAMS : X_IN_W;
   localparam int DY    = (Y_BEAMS < Y_IN_W) ? Y_BEAMS : Y_IN_W;
   localparam int NSTEP = (DX > DY) ? DX : DY;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]    wpos_ff, wpos_in;
   logic                track_ff;
   logic [CNT_W-1:0]    wsamp_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [POS_X_W-1:0]  held_x_ff, held_x_in;
   logic [POS_Y_W-1:0]  held_y_ff, held_y_in;
   logic                rsp_valid_ff;
   logic [POS_X_W-1:0]  pos_x_ff;
   logic [POS_Y_W-1:0]  pos_y_ff;
   logic [X_IN_W-1:0]   xmask_ff;
   logic [Y_IN_W-1:0]   ymask_ff;

   logic                req_acc;
   logic                last_step;
   logic                rsp_space;
   logic                emit;
   lane_ctrl_type       ctrl;
   logic [X_IN_W-1:0]   x_mask;
   logic [Y_IN_W-1:0]   y_mask;
   logic                x_found, y_found;
   logic [POS_X_W-1:0]  x_pos;
   logic [POS_Y_W-1:0]  y_pos;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_acc   = req_port.valid && req_port.ready;
   assign last_step = (step_ff == STEP_W'(NSTEP - 1));
   assign rsp_space = !rsp_valid_ff || rsp_port.ready;
   assign emit      = (state_ff == ST_EMIT) && rsp_space;

   always_comb begin
      ctrl.load        = req_acc;
      ctrl.run         = (state_ff == ST_COUNT) || (state_ff == ST_CLOSE);
      ctrl.close       = (state_ff == ST_CLOSE);
      ctrl.clear_stuck = csr_wr_en && (csr_index == CSR_TRACK_MODE);
      ctrl.track_mode  = track_ff;
      ctrl.step        = step_ff;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      wpos_in  = wpos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               step_in = '0;
               if (wpos_ff < wsamp_ff) begin
                  state_in = ST_COUNT;
                  wpos_in  = wpos_ff + CNT_W'(1);
               end else begin
                  state_in = ST_CLOSE;
                  wpos_in  = '0;
               end
            end
         end
         ST_COUNT: begin
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               step_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_CLOSE: begin
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               step_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_space) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   assign held_x_in = x_found ? x_pos : held_x_ff;
   assign held_y_in = y_found ? y_pos : held_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         wpos_ff      <= '0;
         held_x_ff    <= '1;
         held_y_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         wpos_ff  <= wpos_in;
         if (emit) begin
            held_x_ff    <= held_x_in;
            held_y_ff    <= held_y_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pos_x_ff <= held_x_in;
         pos_y_ff <= held_y_in;
         xmask_ff <= x_mask;
         ymask_ff <= y_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff <= 1'b1;
         wsamp_ff <= WINDOW_SAMPLES_RST;
         limit_ff <= STUCK_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TRACK_MODE:     track_ff <= csr_data[0];
            CSR_WINDOW_SAMPLES: wsamp_ff <= csr_data[CNT_W-1:0];
            CSR_STUCK_LIMIT:    limit_ff <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   bbpf_lane #(
      .BEAMS (X_BEAMS),
      .IN_W  (X_IN_W),
      .POS_W (POS_X_W)
   ) u_lane_x (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .load_bits   (req_port.x_beam_breaks),
      .threshold   (wsamp_ff >> 1),
      .stuck_limit (limit_ff),
      .mask        (x_mask),
      .found       (x_found),
      .pos         (x_pos)
   );

   bbpf_lane #(
      .BEAMS (Y_BEAMS),
      .IN_W  (Y_IN_W),
      .POS_W (POS_Y_W)
   ) u_lane_y (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .load_bits   (req_port.y_beam_breaks),
      .threshold   (wsamp_ff >> 1),
      .stuck_limit (limit_ff),
      .mask        (y_mask),
      .found       (y_found),
      .pos         (y_pos)
   );

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.pos_x           = pos_x_ff;
   assign rsp_port.pos_y           = pos_y_ff;
   assign rsp_port.x_filtered_mask = xmask_ff;
   assign rsp_port.y_filtered_mask = ymask_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after a transaction");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the emit step");

   a_held_from_emit: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(held_x_ff)) |-> $past(state_ff == ST_EMIT))
      else $error("held position changed outside the emit step");

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (step_ff == '0))
      else $error("beam step counter not cleared between transactions");
`endif

endmodule

// ----- hw/rtl/bbpf_lane.sv -----
// One axis lane: rotating per-beam counters, stuck tracking and serial position search.
module bbpf_lane #(
   parameter int BEAMS = 32,
   parameter int IN_W  = 32,
   parameter int POS_W = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bbpf_pkg::lane_ctrl_type      ctrl,
   input  logic [IN_W-1:0]              load_bits,
   input  logic [bbpf_pkg::CNT_W-1:0]   threshold,
   input  logic [bbpf_pkg::LIMIT_W-1:0] stuck_limit,
   output logic [IN_W-1:0]              mask,
   output logic                         found,
   output logic [POS_W-1:0]             pos
);
   import bbpf_pkg::*;

   localparam int DEPTH = (BEAMS < IN_W) ? BEAMS : IN_W;

   logic [CNT_W-1:0] cnt_ff [DEPTH];
   logic [STK_W-1:0] stk_ff [DEPTH];
   logic             ign_ff [DEPTH];
   logic [IN_W-1:0]  bits_ff;
   logic [DEPTH-1:0] mask_ff;
   logic             found_ff;
   logic             pend_ff;
   logic [POS_W-1:0] pos_ff;

   logic             active;
   logic             step_en;
   logic             broken;
   logic [CNT_W-1:0] head_cnt_in;
   logic [STK_W-1:0] head_stk_in;
   logic             head_ign_in;
   logic             mbit;

   assign active  = ({1'b0, ctrl.step} < (STEP_W + 1)'(DEPTH));
   assign step_en = ctrl.run && active;
   assign broken  = cnt_ff[0] > threshold;

   always_comb begin
      head_cnt_in = cnt_ff[0] + CNT_W'(bits_ff[0]);
      head_stk_in = stk_ff[0];
      head_ign_in = ign_ff[0];
      mbit        = 1'b0;
      if (ctrl.close) begin
         head_cnt_in = '0;
         if (broken) begin
            if (!ctrl.track_mode) begin
               mbit = 1'b1;
            end else if (!ign_ff[0] && (stk_ff[0] < STK_W'(stuck_limit))) begin
               mbit        = 1'b1;
               head_stk_in = stk_ff[0] + STK_W'(1);
            end else begin
               head_ign_in = 1'b1;
            end
         end else if (ctrl.track_mode) begin
            head_stk_in = '0;
            head_ign_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            cnt_ff[i] <= '0;
            stk_ff[i] <= '0;
            ign_ff[i] <= 1'b0;
         end
      end else if (step_en) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            cnt_ff[i] <= cnt_ff[i+1];
            stk_ff[i] <= stk_ff[i+1];
            ign_ff[i] <= ign_ff[i+1];
         end
         cnt_ff[DEPTH-1] <= head_cnt_in;
         stk_ff[DEPTH-1] <= head_stk_in;
         ign_ff[DEPTH-1] <= head_ign_in;
      end else if (ctrl.clear_stuck) begin
         for (int i = 0; i < DEPTH; i++) begin
            stk_ff[i] <= '0;
            ign_ff[i] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         bits_ff <= load_bits;
         mask_ff <= '0;
      end else if (step_en) begin
         bits_ff <= bits_ff >> 1;
         if (ctrl.close) begin
            mask_ff <= {mbit, mask_ff[DEPTH-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (ctrl.load) begin
         found_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (step_en && ctrl.close) begin
         if (pend_ff) begin
            pend_ff <= 1'b0;
         end else if (!found_ff && mbit) begin
            found_ff <= 1'b1;
            pend_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && ctrl.close) begin
         if (pend_ff) begin
            pos_ff <= pos_ff | POS_W'(mbit);
         end else if (!found_ff && mbit) begin
            pos_ff <= POS_W'({ctrl.step, 1'b0});
         end
      end
   end

   assign mask  = IN_W'(mask_ff);
   assign found = found_ff;
   assign pos   = pos_ff;

endmodule

// ----- sim/tb.sv -----
// Testbench for the beam break position filter: directed and random beam samples checked against a predictor.
module tb;
   import bbpf_pkg::*;

   localparam int SETTLE_CYCLES   = 48;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int TIMEOUT_TICKS   = 4_000_000;

   typedef struct {
      logic [POS_X_W-1:0] pos_x;
      logic [POS_Y_W-1:0] pos_y;
      logic [X_IN_W-1:0]  x_mask;
      logic [Y_IN_W-1:0]  y_mask;
   } fix_type;

   typedef struct {
      logic [STK_W-1:0] count;
      bit               ignored;
   } stuck_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   bbpf_req_if req_bus ();
   bbpf_rsp_if rsp_bus ();

   beam_break_position_filter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   logic               cfg_track;
   logic [CNT_W-1:0]   cfg_window;
   logic [LIMIT_W-1:0] cfg_limit;
   logic [CNT_W-1:0]   win_pos;
   logic [CNT_W-1:0]   x_hits [X_IN_W];
   logic [CNT_W-1:0]   y_hits [Y_IN_W];
   stuck_type          x_stuck [X_IN_W];
   stuck_type          y_stuck [Y_IN_W];
   logic [POS_X_W-1:0] held_x;
   logic [POS_Y_W-1:0] held_y;
   fix_type            pending_fixes [$];

   int error_count;
   int samples_sent;
   int burst_left;
   bit sender_gapless;
   int rsp_hold_requests;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_TICKS);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (error_count < 40) $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic clear_stuck_model();
      for (int b = 0; b < X_IN_W; b++) x_stuck[b] = '{count: '0, ignored: 1'b0};
      for (int b = 0; b < Y_IN_W; b++) y_stuck[b] = '{count: '0, ignored: 1'b0};
   endtask

   function automatic bit judge_beam(input logic [CNT_W-1:0] hits, inout stuck_type st);
      bit broken;
      broken = 1'b0;
      if (hits > (cfg_window >> 1)) begin
         if (!cfg_track) begin
            broken = 1'b1;
         end else if (!st.ignored && st.count < {1'b0, cfg_limit}) begin
            broken   = 1'b1;
            st.count = st.count + 1'b1;
         end else begin
            st.ignored = 1'b1;
         end
      end else if (cfg_track) begin
         st.count   = '0;
         st.ignored = 1'b0;
      end
      return broken;
   endfunction

   function automatic int unsigned lowest_position(input logic [63:0] mask, input int width,
                                                   input int unsigned held);
      for (int b = 0; b < width; b++) begin
         if (mask[b]) return (b + 1 < width && mask[b+1]) ? 2 * b + 1 : 2 * b;
      end
      return held;
   endfunction

   task automatic predict_sample(input logic [X_IN_W-1:0] xb, input logic [Y_IN_W-1:0] yb);
      logic [X_IN_W-1:0] xm;
      logic [Y_IN_W-1:0] ym;
      fix_type           fix;
      if (win_pos < cfg_window) begin
         for (int b = 0; b < X_IN_W; b++) if (xb[b]) x_hits[b] = x_hits[b] + 1'b1;
         for (int b = 0; b < Y_IN_W; b++) if (yb[b]) y_hits[b] = y_hits[b] + 1'b1;
         win_pos = win_pos + 1'b1;
      end else begin
         for (int b = 0; b < X_IN_W; b++) begin
            xm[b]     = judge_beam(x_hits[b], x_stuck[b]);
            x_hits[b] = '0;
         end
         for (int b = 0; b < Y_IN_W; b++) begin
            ym[b]     = judge_beam(y_hits[b], y_stuck[b]);
            y_hits[b] = '0;
         end
         held_x = POS_X_W'(lowest_position({32'b0, xm}, X_IN_W, 32'(held_x)));
         held_y = POS_Y_W'(lowest_position({48'b0, ym}, Y_IN_W, 32'(held_y)));
         fix.pos_x  = held_x;
         fix.pos_y  = held_y;
         fix.x_mask = xm;
         fix.y_mask = ym;
         pending_fixes.push_back(fix);
         win_pos = '0;
      end
   endtask

   always @(posedge clock) begin : check_results
      fix_type want;
      if (!reset && req_bus.valid && req_bus.ready)
         predict_sample(req_bus.x_beam_breaks, req_bus.y_beam_breaks);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_fixes.size() == 0) begin
            report_mismatch("result transaction with no closed window pending");
         end else begin
            want = pending_fixes.pop_front();
            if (rsp_bus.pos_x !== want.pos_x)
               report_mismatch($sformatf("pos_x %0d, want %0d", rsp_bus.pos_x,
                                         $signed(want.pos_x)));
            if (rsp_bus.pos_y !== want.pos_y)
               report_mismatch($sformatf("pos_y %0d, want %0d", rsp_bus.pos_y,
                                         $signed(want.pos_y)));
            if (rsp_bus.x_filtered_mask !== want.x_mask)
               report_mismatch($sformatf("x_filtered_mask %h, want %h",
                                         rsp_bus.x_filtered_mask, want.x_mask));
            if (rsp_bus.y_filtered_mask !== want.y_mask)
               report_mismatch($sformatf("y_filtered_mask %h, want %h",
                                         rsp_bus.y_filtered_mask, want.y_mask));
         end
      end
   end

   initial begin : rsp_stall_pattern
      int mode;
      int mode_left;
      int hold_left;
      int seen_hold;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      seen_hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_requests != seen_hold) begin
            seen_hold = rsp_hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(5, 60);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_sample(input logic [X_IN_W-1:0] xb, input logic [Y_IN_W-1:0] yb);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = sender_gapless ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8));
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.x_beam_breaks <= xb;
      req_bus.y_beam_breaks <= yb;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_window(input logic [X_IN_W-1:0] xt, input logic [Y_IN_W-1:0] yt,
                              input int jitter);
      logic [X_IN_W-1:0] xj;
      logic [Y_IN_W-1:0] yj;
      while (win_pos < cfg_window) begin
         xj = '0;
         yj = '0;
         if (jitter == 1) begin
            xj = $urandom & $urandom & $urandom;
            yj = Y_IN_W'($urandom & $urandom & $urandom);
         end else if (jitter == 2) begin
            xj = $urandom & $urandom;
            yj = Y_IN_W'($urandom & $urandom);
         end
         send_sample(xt ^ xj, yt ^ yj);
      end
      send_sample($urandom, Y_IN_W'($urandom));
   endtask

   task automatic settle();
      int waited;
      req_bus.valid <= 1'b0;
      burst_left = 0;
      waited = 0;
      while (pending_fixes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_fixes.size() != 0) begin
         report_mismatch($sformatf("%0d window results never arrived", pending_fixes.size()));
         pending_fixes.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_TRACK_MODE: begin
            cfg_track = value[0];
            clear_stuck_model();
         end
         CSR_WINDOW_SAMPLES: cfg_window = value[CNT_W-1:0];
         CSR_STUCK_LIMIT:    cfg_limit  = value[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic test_reset_defaults();
      for (int i = 0; i < 10; i++)
         send_sample(i < 5 ? {X_IN_W{1'b1}} : {X_IN_W{1'b0}},
                     i < 5 ? {Y_IN_W{1'b1}} : (i == 5 ? 16'h8000 : 16'h0000));
      send_sample({X_IN_W{1'b1}}, {Y_IN_W{1'b1}});
   endtask

   task automatic test_zero_window();
      settle();
      write_reg(CSR_WINDOW_SAMPLES, CSR_DATA_W'(0));
      send_sample({X_IN_W{1'b1}}, {Y_IN_W{1'b1}});
      send_sample('0, '0);
   endtask

   task automatic test_edge_beams();
      settle();
      write_reg(CSR_WINDOW_SAMPLES, CSR_DATA_W'(1));
      send_sample(32'h8000_0000, 16'h8000);
      send_sample('0, '0);
      send_sample(32'hC000_0000, 16'hC000);
      send_sample({X_IN_W{1'b1}}, {Y_IN_W{1'b1}});
   endtask

   task automatic test_plain_majority();
      settle();
      write_reg(CSR_TRACK_MODE, CSR_DATA_W'(0));
      send_sample({X_IN_W{1'b1}}, {Y_IN_W{1'b1}});
      send_sample('0, '0);
   endtask

   task automatic test_stuck_masking();
      settle();
      write_reg(CSR_TRACK_MODE, CSR_DATA_W'(1));
      write_reg(CSR_STUCK_LIMIT, CSR_DATA_W'(0));
      send_sample({X_IN_W{1'b1}}, {Y_IN_W{1'b1}});
      send_sample('0, '0);
      settle();
      write_reg(CSR_STUCK_LIMIT, CSR_DATA_W'(1));
      write_reg(CSR_TRACK_MODE, CSR_DATA_W'(1));
      for (int w = 0; w < 4; w++) begin
         send_sample(w == 2 ? 32'h0 : 32'h0000_0020, w == 2 ? 16'h0 : 16'h0008);
         send_sample('0, '0);
      end
   endtask

   task automatic test_window_shrink();
      settle();
      write_reg(CSR_WINDOW_SAMPLES, CSR_DATA_W'(4));
      repeat (3) send_sample(32'h0001_0000, 16'h0100);
      settle();
      write_reg(CSR_WINDOW_SAMPLES, CSR_DATA_W'(2));
      send_sample('0, '0);
   endtask

   task automatic test_result_backpressure();
      settle();
      write_reg(CSR_TRACK_MODE, CSR_DATA_W'(0));
      write_reg(CSR_WINDOW_SAMPLES, CSR_DATA_W'(1));
      rsp_hold_requests++;
      sender_gapless = 1'b1;
      repeat (60) send_sample($urandom, Y_IN_W'($urandom));
      sender_gapless = 1'b0;
   endtask

   task automatic test_random_windows();
      int unsigned       track_set  [8] = '{1, 0, 1, 1, 1, 0, 1, 1};
      int unsigned       window_set [8] = '{1, 2, 3, 5, 0, 8, 4, 21};
      int unsigned       limit_set  [8] = '{1, 2, 3, 1000, 0, 1023, 5, 2};
      logic [X_IN_W-1:0] xt;
      logic [X_IN_W-1:0] x_stuck_mask;
      logic [Y_IN_W-1:0] yt;
      logic [Y_IN_W-1:0] y_stuck_mask;
      int                phase_start;
      int                pick;
      for (int p = 0; p < 8; p++) begin
         settle();
         write_reg(CSR_TRACK_MODE, CSR_DATA_W'(track_set[p]));
         write_reg(CSR_WINDOW_SAMPLES, CSR_DATA_W'(window_set[p]));
         write_reg(CSR_STUCK_LIMIT, CSR_DATA_W'(limit_set[p]));
         x_stuck_mask = $urandom & $urandom & $urandom;
         y_stuck_mask = Y_IN_W'($urandom & $urandom & $urandom);
         xt = '0;
         yt = '0;
         phase_start = samples_sent;
         while (samples_sent - phase_start < 45) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
               repeat ($urandom_range(1, 5)) send_sample($urandom, Y_IN_W'($urandom));
            end else begin
               if (pick >= 8 && pick < 14 || pick >= 18) begin
                  xt = 32'd1 << $urandom_range(0, X_IN_W - 1);
                  yt = 16'd1 << $urandom_range(0, Y_IN_W - 1);
                  if ($urandom_range(0, 1)) xt = xt | (xt << 1);
                  if ($urandom_range(0, 1)) yt = yt | (yt << 1);
               end else if (pick >= 14 && pick < 16) begin
                  xt = $urandom;
                  yt = Y_IN_W'($urandom);
               end else if (pick == 16) begin
                  xt = '0;
                  yt = '0;
               end else if (pick == 17) begin
                  xt = '1;
                  yt = '1;
               end
               if (pick < 14 && $urandom_range(0, 3) != 0) begin
                  xt = xt | x_stuck_mask;
                  yt = yt | y_stuck_mask;
               end
               send_window(xt, yt, $urandom_range(0, 2));
            end
         end
      end
   endtask

   task automatic test_long_window();
      settle();
      write_reg(CSR_WINDOW_SAMPLES, CSR_DATA_W'(255));
      write_reg(CSR_STUCK_LIMIT, CSR_DATA_W'(1000));
      send_window($urandom, Y_IN_W'($urandom), 2);
   endtask

   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_index             = '0;
      csr_data              = '0;
      req_bus.valid         = 1'b0;
      req_bus.x_beam_breaks = '0;
      req_bus.y_beam_breaks = '0;
      error_count       = 0;
      samples_sent      = 0;
      burst_left        = 0;
      sender_gapless    = 1'b0;
      rsp_hold_requests = 0;
      cfg_track  = 1'b1;
      cfg_window = WINDOW_SAMPLES_RST;
      cfg_limit  = STUCK_LIMIT_RST;
      win_pos    = '0;
      for (int b = 0; b < X_IN_W; b++) x_hits[b] = '0;
      for (int b = 0; b < Y_IN_W; b++) y_hits[b] = '0;
      clear_stuck_model();
      held_x = '1;
      held_y = '1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_window();
      test_edge_beams();
      test_plain_majority();
      test_stuck_masking();
      test_window_shrink();
      test_result_backpressure();
      test_random_windows();
      test_long_window();

      settle();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/bbpf_pkg.sv
hw/rtl/bbpf_if.sv
hw/rtl/bbpf_lane.sv
hw/rtl/beam_break_position_filter_top.sv
sim/tb.sv
